### rtl/cvf_pkg.sv
// ----------------------------------------------------------------------------
// cvf_pkg
// Shared types, constants and helpers of the 3x3 valid-only filter core.
// ----------------------------------------------------------------------------
package cvf_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 4096;
	localparam int KERNEL_SIZE = 3;
	localparam int CENTRE      = KERNEL_SIZE / 2;

	localparam int PIX_W    = 32;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int CFG_WD_W = 12;
	localparam int CFG_HT_W = 13;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CFG_WD_W-1:0] CFG_WD_RESET = 12'd2048;
	localparam logic [CFG_HT_W-1:0] CFG_HT_RESET = 13'd2048;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cvf_reg_t;

	// one window column, oldest row on top
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} cvf_col_t;

	// last column index of a row, width clamped to the supported range
	function automatic logic [COL_W-1:0] width_last(input logic [CFG_WD_W-1:0] fw);
		int v;
		v = int'(fw);
		if (v < KERNEL_SIZE) v = KERNEL_SIZE;
		if (v > MAX_WIDTH) v = MAX_WIDTH;
		return COL_W'(v - 1);
	endfunction

	// last row index of a frame, height clamped to the supported range
	function automatic logic [ROW_W-1:0] height_last(input logic [CFG_HT_W-1:0] fh);
		int v;
		v = int'(fh);
		if (v < KERNEL_SIZE) v = KERNEL_SIZE;
		if (v > MAX_HEIGHT) v = MAX_HEIGHT;
		return ROW_W'(v - 1);
	endfunction

endpackage

### rtl/cvf_pix_if.sv
// ----------------------------------------------------------------------------
// cvf_pix_if
// Pixel stream channel: valid/ready with one signed pixel per beat.
// ----------------------------------------------------------------------------
interface cvf_pix_if;
	logic                             valid;
	logic                             ready;
	logic signed [cvf_pkg::PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

### rtl/cvf_res_if.sv
// ----------------------------------------------------------------------------
// cvf_res_if
// Result stream channel: valid/ready with filtered value and frame end flag.
// ----------------------------------------------------------------------------
interface cvf_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [cvf_pkg::PIX_W-1:0] filtered_value;
	logic                             frame_last;

	modport source (output valid, output filtered_value, output frame_last, input ready);
	modport sink   (input valid, input filtered_value, input frame_last, output ready);
endinterface

### rtl/cvf_ram.sv
// ----------------------------------------------------------------------------
// cvf_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module cvf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/cvf_cell.sv
// ----------------------------------------------------------------------------
// cvf_cell
// One window column: holds three pixels and their column sum, loads the
// neighbouring column on every shift.
// ----------------------------------------------------------------------------
module cvf_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  cvf_pkg::cvf_col_t           col_in,
	output cvf_pkg::cvf_col_t           col,
	output logic [cvf_pkg::PIX_W-1:0]   col_sum
);

	cvf_pkg::cvf_col_t         col_q;
	logic [cvf_pkg::PIX_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
			sum_q <= col_in.top + col_in.mid + col_in.bot;
		end
	end

	assign col     = col_q;
	assign col_sum = sum_q;

endmodule

### rtl/conv3x3_valid_filter_core.sv
// ----------------------------------------------------------------------------
// conv3x3_valid_filter_core
// 3x3 valid-only convolution, kernel centre 4 and neighbours -1.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the pix channel, one per beat. Each beat
// writes two line buffers (RAMs of MAX_WIDTH words) and shifts a row of three
// column cells that hold the window. A result beat leaves on res only where
// the whole window lies in the frame: (W-2)*(H-2) beats per frame, the last
// one flagged with frame_last. Sums wrap to 32 bits.
// Throughput: one pixel per cycle while res does not stall, limited by the
// single write port of each line buffer. A result passes the window cells,
// the sum stage and the output register in order before it reaches res.
// When res stalls the three stages fill and pix.ready drops; nothing is lost.
// Reset clears the counters and stage valids and sets width and height to
// 2048; line buffers are not cleared, no result reads an entry not written
// earlier in the same frame. An APB write to frame_width (0x0) or
// frame_height (0x4) restarts the frame; write only while the core is idle.
// ----------------------------------------------------------------------------
module conv3x3_valid_filter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	cvf_pix_if.sink                         pix,
	cvf_res_if.source                       res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cvf_pkg::PADDR_W-1:0]     paddr,
	input  logic [cvf_pkg::PDATA_W-1:0]     pwdata,
	output logic [cvf_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int NC = cvf_pkg::KERNEL_SIZE;

	// configuration
	logic [cvf_pkg::CFG_WD_W-1:0] fw_q;
	logic [cvf_pkg::CFG_HT_W-1:0] fh_q;
	logic [cvf_pkg::COL_W-1:0]    w_last_q;
	logic [cvf_pkg::ROW_W-1:0]    h_last_q;
	logic                         cfg_wr;
	cvf_pkg::cvf_reg_t            reg_sel;

	// position
	logic [cvf_pkg::COL_W-1:0] col_q, col_d;
	logic [cvf_pkg::ROW_W-1:0] row_q, row_d;
	logic                      due, at_last;

	// handshake and stages
	logic en_s1, en_s2, en_s3, acc;
	logic v_s1, v_s2, v_s3;
	logic last_s1, last_s2, last_s3;
	logic [cvf_pkg::PIX_W-1:0] tot_s2, cen5_s2, res_s3;

	// line buffers and window
	logic [cvf_pkg::PIX_W-1:0] rd_mid, rd_top;
	cvf_pkg::cvf_col_t         cols [NC];
	logic [cvf_pkg::PIX_W-1:0] sums [NC];
	cvf_pkg::cvf_col_t         new_col;
	logic [cvf_pkg::PIX_W-1:0] tot_d, cen;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = cvf_pkg::cvf_reg_t'(paddr[2]);

	always_comb begin
		prdata = '0;
		case (reg_sel)
			cvf_pkg::REG_FRAME_WIDTH:  prdata = cvf_pkg::PDATA_W'(fw_q);
			cvf_pkg::REG_FRAME_HEIGHT: prdata = cvf_pkg::PDATA_W'(fh_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= cvf_pkg::CFG_WD_RESET;
			fh_q     <= cvf_pkg::CFG_HT_RESET;
			w_last_q <= cvf_pkg::width_last(cvf_pkg::CFG_WD_RESET);
			h_last_q <= cvf_pkg::height_last(cvf_pkg::CFG_HT_RESET);
		end else if (cfg_wr) begin
			case (reg_sel)
				cvf_pkg::REG_FRAME_WIDTH: begin
					fw_q     <= pwdata[cvf_pkg::CFG_WD_W-1:0];
					w_last_q <= cvf_pkg::width_last(pwdata[cvf_pkg::CFG_WD_W-1:0]);
				end
				cvf_pkg::REG_FRAME_HEIGHT: begin
					fh_q     <= pwdata[cvf_pkg::CFG_HT_W-1:0];
					h_last_q <= cvf_pkg::height_last(pwdata[cvf_pkg::CFG_HT_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// elastic pipeline: a stage moves when it is empty or the next one moves
	assign en_s3     = !v_s3 || res.ready;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign pix.ready = en_s1;
	assign acc       = pix.valid && en_s1;

	assign due     = (row_q >= cvf_pkg::ROW_W'(2)) && (col_q >= cvf_pkg::COL_W'(2));
	assign at_last = (row_q == h_last_q) && (col_q == w_last_q);

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (cfg_wr) begin
			col_d = '0;
			row_d = '0;
		end else if (acc) begin
			if (col_q == w_last_q) begin
				col_d = '0;
				row_d = (row_q == h_last_q) ? '0 : row_q + 1'b1;
			end else begin
				col_d = col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// read address runs one beat ahead so the row above is ready at the beat
	cvf_ram #(.WIDTH(cvf_pkg::PIX_W), .DEPTH(cvf_pkg::MAX_WIDTH)) u_line_mid (
		.clk   (clk),
		.we    (acc),
		.waddr (col_q),
		.wdata (pix.pixel_value),
		.raddr (col_d),
		.rdata (rd_mid)
	);

	cvf_ram #(.WIDTH(cvf_pkg::PIX_W), .DEPTH(cvf_pkg::MAX_WIDTH)) u_line_top (
		.clk   (clk),
		.we    (acc),
		.waddr (col_q),
		.wdata (rd_mid),
		.raddr (col_d),
		.rdata (rd_top)
	);

	assign new_col.top = rd_top;
	assign new_col.mid = rd_mid;
	assign new_col.bot = pix.pixel_value;

	// cell NC-1 holds the newest column
	for (genvar k = 0; k < NC; k++) begin : g_cell
		if (k == NC - 1) begin : g_head
			cvf_cell u_cell (
				.clk     (clk),
				.shift   (acc),
				.col_in  (new_col),
				.col     (cols[k]),
				.col_sum (sums[k])
			);
		end else begin : g_body
			cvf_cell u_cell (
				.clk     (clk),
				.shift   (acc),
				.col_in  (cols[k+1]),
				.col     (cols[k]),
				.col_sum (sums[k])
			);
		end
	end

	// 4*centre - neighbours == 5*centre - all nine
	always_comb begin
		tot_d = '0;
		for (int k = 0; k < NC; k++) begin
			tot_d = tot_d + sums[k];
		end
	end
	assign cen = cols[cvf_pkg::CENTRE].mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= acc && due;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			last_s1 <= at_last;
		end
		if (en_s2) begin
			last_s2 <= last_s1;
			tot_s2  <= tot_d;
			cen5_s2 <= {cen[cvf_pkg::PIX_W-3:0], 2'b00} + cen;
		end
		if (en_s3) begin
			last_s3 <= last_s2;
			res_s3  <= cen5_s2 - tot_s2;
		end
	end

	assign res.valid          = v_s3;
	assign res.filtered_value = res_s3;
	assign res.frame_last     = last_s3;

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last_q)
		else $error("column counter past end of row");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_last_q)
		else $error("row counter past end of frame");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && at_last) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap after last pixel of frame");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !res.ready) |-> !pix.ready)
		else $error("pixel taken while all stages full and stalled");
`endif

endmodule

### dv/conv3x3_valid_filter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_valid_filter_core_test
// Self-checking bench for the 3x3 valid-only filter core.
// ----------------------------------------------------------------------------
// Pixels go in over the pix channel with random source gaps, and results are
// taken with random sink stalls. A scoreboard keeps its own line buffers,
// window and raster position, works out each result from the accepted pixels
// and compares every result beat field by field. Frame sizes are set over APB
// between phases: the reset size, the clamped extremes, small frames, partial
// frames and back-to-back frames.
// ----------------------------------------------------------------------------
module conv3x3_valid_filter_core_test;

	typedef struct {
		logic [cvf_pkg::PIX_W-1:0] filtered_value;
		logic                      frame_last;
	} filt_res_t;

	// usable frame dimension: below a full kernel or above the given maximum is clamped
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < cvf_pkg::KERNEL_SIZE) return cvf_pkg::KERNEL_SIZE;
		if (v > hi) return hi;
		return v;
	endfunction

	class conv_scoreboard;
		logic [cvf_pkg::PIX_W-1:0]    row_above [cvf_pkg::MAX_WIDTH];
		logic [cvf_pkg::PIX_W-1:0]    row_above2 [cvf_pkg::MAX_WIDTH];
		logic [cvf_pkg::PIX_W-1:0]    win [cvf_pkg::KERNEL_SIZE][cvf_pkg::KERNEL_SIZE];
		logic [cvf_pkg::CFG_WD_W-1:0] width_cfg;
		logic [cvf_pkg::CFG_HT_W-1:0] height_cfg;
		int unsigned                  col;
		int unsigned                  row;
		filt_res_t                    expected_q[$];
		int                           errors;

		function new();
			width_cfg  = cvf_pkg::CFG_WD_RESET;
			height_cfg = cvf_pkg::CFG_HT_RESET;
			col        = 0;
			row        = 0;
			errors     = 0;
			foreach (row_above[i]) begin
				row_above[i]  = '0;
				row_above2[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
		endfunction

		// any register write restarts the frame, buffers and window are kept
		function void write_reg(input cvf_pkg::cvf_reg_t r,
				input logic [cvf_pkg::PDATA_W-1:0] d);
			case (r)
				cvf_pkg::REG_FRAME_WIDTH:  width_cfg  = d[cvf_pkg::CFG_WD_W-1:0];
				cvf_pkg::REG_FRAME_HEIGHT: height_cfg = d[cvf_pkg::CFG_HT_W-1:0];
				default: ;
			endcase
			col = 0;
			row = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_pixel(input logic [cvf_pkg::PIX_W-1:0] px);
			int unsigned               w;
			int unsigned               h;
			logic [cvf_pkg::PIX_W-1:0] above;
			logic [cvf_pkg::PIX_W-1:0] above2;
			logic [cvf_pkg::PIX_W-1:0] sum;
			filt_res_t                 e;
			w      = clamp_dim(width_cfg, cvf_pkg::MAX_WIDTH);
			h      = clamp_dim(height_cfg, cvf_pkg::MAX_HEIGHT);
			above  = row_above[col];
			above2 = row_above2[col];
			row_above2[col] = above;
			row_above[col]  = px;
			for (int k = 0; k < cvf_pkg::KERNEL_SIZE; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = above2;
			win[1][2] = above;
			win[2][2] = px;
			if (row >= 2 && col >= 2) begin
				sum = win[cvf_pkg::CENTRE][cvf_pkg::CENTRE] << 2;
				for (int i = 0; i < cvf_pkg::KERNEL_SIZE; i++)
					for (int j = 0; j < cvf_pkg::KERNEL_SIZE; j++)
						if (!(i == cvf_pkg::CENTRE && j == cvf_pkg::CENTRE))
							sum = sum - win[i][j];
				e.filtered_value = sum;
				e.frame_last     = (row == h - 1) && (col == w - 1);
				expected_q.push_back(e);
			end
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_result(input logic [cvf_pkg::PIX_W-1:0] v, input logic last);
			filt_res_t e;
			if (expected_q.size() == 0) begin
				$error("result beat with none expected: filtered_value %0d frame_last %0b",
					$signed(v), last);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (v !== e.filtered_value) begin
				$error("filtered_value: expected %0d, actual %0d",
					$signed(e.filtered_value), $signed(v));
				errors++;
			end
			if (last !== e.frame_last) begin
				$error("frame_last: expected %0b, actual %0b", e.frame_last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [cvf_pkg::PADDR_W-1:0] paddr;
	logic [cvf_pkg::PDATA_W-1:0] pwdata;
	logic [cvf_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic gaps_on;

	cvf_pix_if pix_ch ();
	cvf_res_if res_ch ();

	conv_scoreboard sb = new();

	conv3x3_valid_filter_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready)
				sb.note_pixel(pix_ch.pixel_value);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.filtered_value, res_ch.frame_last);
		end
	end

	// result sink: random stall bursts while gaps are on
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	function automatic logic [cvf_pkg::PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic cfg_write(input cvf_pkg::cvf_reg_t r, input int unsigned d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(r, d);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_pixel(input logic [cvf_pkg::PIX_W-1:0] v);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel_value <= v;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	task automatic send_random(input int unsigned n);
		repeat (n) send_pixel(rand_pixel());
	endtask

	// idle the source, wait out every expected beat plus the pipeline tail
	task automatic drain();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		cfg_write(cvf_pkg::REG_FRAME_WIDTH, w);
		cfg_write(cvf_pkg::REG_FRAME_HEIGHT, h);
	endtask

	logic [cvf_pkg::PIX_W-1:0] edge_frame_a [9] = '{
		32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
		32'h8000_0000, 32'h8000_0000, 32'h8000_0000
	};
	logic [cvf_pkg::PIX_W-1:0] edge_frame_b [9] = '{
		32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
		32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff,
		32'hffff_ffff, 32'h0000_0000, 32'h8000_0001
	};

	initial begin
		int unsigned w_raw;
		int unsigned h_raw;
		int unsigned frame_px;
		int unsigned n;
		int unsigned random_items;
		w_raw              = cvf_pkg::CFG_WD_RESET;
		h_raw              = cvf_pkg::CFG_HT_RESET;
		random_items       = 0;
		gaps_on            = 1'b1;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		pix_ch.valid       <= 1'b0;
		pix_ch.pixel_value <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset size: start of a full-width row, no window is complete yet
		send_random(100);
		drain();

		// smallest frame, extreme windows; second frame starts without a write
		set_size(3, 3);
		foreach (edge_frame_a[i]) send_pixel(edge_frame_a[i]);
		foreach (edge_frame_b[i]) send_pixel(edge_frame_b[i]);
		drain();

		// width above range clamps to the buffer size, height below to a kernel
		set_size(4095, 1);
		send_random(100);
		drain();

		// narrowest rows, height above range clamps to the maximum
		set_size(2, 8191);
		send_random(cvf_pkg::KERNEL_SIZE * 20);
		drain();

		w_raw = 2;
		h_raw = 8191;
		while (random_items < 700) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					w_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
					h_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
					set_size(w_raw, h_raw);
				end
				2: begin
					w_raw = $urandom_range(0, 10);
					cfg_write(cvf_pkg::REG_FRAME_WIDTH, w_raw);
				end
				default: begin
					h_raw = $urandom_range(0, 7);
					cfg_write(cvf_pkg::REG_FRAME_HEIGHT, h_raw);
				end
			endcase
			// the other register may still hold a large extreme size
			if (clamp_dim(w_raw, cvf_pkg::MAX_WIDTH) * clamp_dim(h_raw, cvf_pkg::MAX_HEIGHT) > 100)
			begin
				w_raw = $urandom_range(3, 10);
				h_raw = $urandom_range(3, 7);
				set_size(w_raw, h_raw);
			end
			frame_px = clamp_dim(w_raw, cvf_pkg::MAX_WIDTH) * clamp_dim(h_raw, cvf_pkg::MAX_HEIGHT);
			// mostly whole frames; some phases cut a frame short before the next write
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, 2 * frame_px);
			else
				n = $urandom_range(1, 3) * frame_px;
			gaps_on = ($urandom_range(0, 3) != 0);
			send_random(n);
			random_items += n;
			drain();
		end

		// closing stretch at full rate
		gaps_on = 1'b0;
		set_size(6, 5);
		send_random(3 * 6 * 5);
		drain();

		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### conv3x3_valid_filter_core.f
rtl/cvf_pkg.sv
rtl/cvf_pix_if.sv
rtl/cvf_res_if.sv
rtl/cvf_ram.sv
rtl/cvf_cell.sv
rtl/conv3x3_valid_filter_core.sv
dv/conv3x3_valid_filter_core_test.sv
